### rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Action codes and the classified word passed from the front to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
package fpa_pkg;

	typedef enum logic [3:0] {
		ACT_ADD      = 4'd0,
		ACT_SUB      = 4'd1,
		ACT_MUL      = 4'd2,
		ACT_DIV      = 4'd3,
		ACT_MIN      = 4'd4,
		ACT_MAX      = 4'd5,
		ACT_ABS      = 4'd6,
		ACT_INC      = 4'd7,
		ACT_DEC      = 4'd8,
		ACT_TO_INT   = 4'd9,
		ACT_FROM_INT = 4'd10
	} action_t;

	// Flags that ride along with every word.
	typedef struct packed {
		logic a_less;
		logic a_equal;
		logic a_greater;
		logic overflow;
		logic divide_by_zero;
	} flags_t;

endpackage
`default_nettype wire

### rtl/fpa_front.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Accepts words, computes the cheap actions and the comparison flags, and
// sets up sign and magnitudes for the multiply and divide in the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_front #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [3:0]            action,
	input  wire logic [DATA_WIDTH-1:0] operand_a,
	input  wire logic [DATA_WIDTH-1:0] operand_b,
	output logic                       f_valid,
	input  wire logic                  f_ready,
	output logic [3:0]                 f_action,
	output logic                       f_neg,
	output logic [DATA_WIDTH-1:0]      f_mag_a,
	output logic [DATA_WIDTH-1:0]      f_mag_b,
	output logic [DATA_WIDTH-1:0]      f_simple,
	output fpa_pkg::flags_t            f_flags
);
	localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MINNEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	logic                  valid_q;
	logic                  sa, sb;
	logic [DATA_WIDTH-1:0] mag_a, mag_b, res, sum, dif;
	logic                  lt, eq, gt, ovf;
	logic [DATA_WIDTH+FRAC_BITS-1:0] shl;

	assign in_ready = !valid_q || f_ready;
	assign f_valid  = valid_q;

	always_comb begin
		sa    = operand_a[DATA_WIDTH-1];
		sb    = operand_b[DATA_WIDTH-1];
		mag_a = sa ? (~operand_a + 1'b1) : operand_a;
		mag_b = sb ? (~operand_b + 1'b1) : operand_b;
		lt    = $signed(operand_a) < $signed(operand_b);
		eq    = operand_a == operand_b;
		gt    = !lt && !eq;
		sum   = operand_a + operand_b;
		dif   = operand_a - operand_b;
		shl   = {{FRAC_BITS{1'b0}}, mag_a} << FRAC_BITS;
		ovf   = 1'b0;
		res   = '0;
		case (action)
			fpa_pkg::ACT_ADD: begin
				res = sum;
				if (sa == sb && sum[DATA_WIDTH-1] != sa) begin
					ovf = 1'b1;
					res = sa ? MINNEG : MAXPOS;
				end
			end
			fpa_pkg::ACT_SUB: begin
				res = dif;
				if (sa != sb && dif[DATA_WIDTH-1] != sa) begin
					ovf = 1'b1;
					res = sa ? MINNEG : MAXPOS;
				end
			end
			fpa_pkg::ACT_MIN: res = lt ? operand_a : operand_b;
			fpa_pkg::ACT_MAX: res = gt ? operand_a : operand_b;
			fpa_pkg::ACT_ABS: begin
				res = mag_a;
				if (operand_a == MINNEG) begin
					ovf = 1'b1;
					res = MAXPOS;
				end
			end
			fpa_pkg::ACT_INC: begin
				res = operand_a + 1'b1;
				if (operand_a == MAXPOS) begin
					ovf = 1'b1;
					res = MAXPOS;
				end
			end
			fpa_pkg::ACT_DEC: begin
				res = operand_a - 1'b1;
				if (operand_a == MINNEG) begin
					ovf = 1'b1;
					res = MINNEG;
				end
			end
			fpa_pkg::ACT_TO_INT: res = DATA_WIDTH'($signed(operand_a) >>> FRAC_BITS);
			fpa_pkg::ACT_FROM_INT: begin
				if (shl[DATA_WIDTH+FRAC_BITS-1:DATA_WIDTH] != '0
					|| shl[DATA_WIDTH-1:0] > (sa ? MINNEG : MAXPOS)) begin
					ovf = 1'b1;
					res = sa ? MINNEG : MAXPOS;
				end else begin
					res = sa ? (~shl[DATA_WIDTH-1:0] + 1'b1) : shl[DATA_WIDTH-1:0];
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			f_action                 <= action;
			f_neg                    <= sa ^ sb;
			f_mag_a                  <= mag_a;
			f_mag_b                  <= mag_b;
			f_simple                 <= res;
			f_flags.a_less           <= lt;
			f_flags.a_equal          <= eq;
			f_flags.a_greater        <= gt;
			f_flags.overflow         <= ovf;
			f_flags.divide_by_zero   <= (action == fpa_pkg::ACT_DIV) && (operand_b == '0);
		end
	end

endmodule
`default_nettype wire

### rtl/fpa_queue.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU decoupling queue
// A two-entry queue that lets front and back end stall independently.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             w_valid,
	output logic                  w_ready,
	input  wire logic [WIDTH-1:0] w_data,
	output logic                  r_valid,
	input  wire logic             r_ready,
	output logic [WIDTH-1:0]      r_data
);
	logic [WIDTH-1:0] mem_q [2];
	logic             wp_q, rp_q;
	logic [1:0]       cnt_q;
	logic             wr, rd;

	assign w_ready = cnt_q != 2'd2;
	assign r_valid = cnt_q != 2'd0;
	assign r_data  = mem_q[rp_q];
	assign wr      = w_valid && w_ready;
	assign rd      = r_valid && r_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= w_data;
	end

endmodule
`default_nettype wire

### rtl/fpa_back.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Pipelined multiplier and a radix-2 divider pipeline, one quotient bit per
// stage, followed by saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_back #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  b_valid,
	output logic                       b_ready,
	input  wire logic [3:0]            b_action,
	input  wire logic                  b_neg,
	input  wire logic [DATA_WIDTH-1:0] b_mag_a,
	input  wire logic [DATA_WIDTH-1:0] b_mag_b,
	input  wire logic [DATA_WIDTH-1:0] b_simple,
	input  wire fpa_pkg::flags_t       b_flags,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      out_result,
	output fpa_pkg::flags_t            out_flags
);
	localparam int NW = DATA_WIDTH + FRAC_BITS;   // dividend and quotient width
	localparam int ST = NW + 2;                   // pipeline stages
	localparam int PW = 2 * DATA_WIDTH;
	localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MINNEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	// Stage arrays: index k holds the word after k stages.
	logic                  v_q   [ST+1];
	logic [3:0]            act_q [ST+1];
	logic                  neg_q [ST+1];
	logic [DATA_WIDTH-1:0] sim_q [ST+1];
	fpa_pkg::flags_t       flg_q [ST+1];
	logic [NW-1:0]         num_q [ST+1];   // dividend shifting out, quotient in
	logic [DATA_WIDTH:0]   rem_q [ST+1];
	logic [DATA_WIDTH-1:0] den_q [ST+1];
	logic [PW-1:0]         prod_q;
	logic [PW-1:0]         prod_hold_q [ST+1];
	logic                  adv;
	logic                  last_v;

	assign last_v = v_q[ST];
	assign adv    = !out_valid || out_ready;
	assign b_ready = adv;

	always_comb begin
		v_q[0]   = b_valid;
		act_q[0] = b_action;
		neg_q[0] = b_neg;
		sim_q[0] = b_simple;
		flg_q[0] = b_flags;
		num_q[0] = {b_mag_a, {FRAC_BITS{1'b0}}};
		rem_q[0] = '0;
		den_q[0] = b_mag_b;
		prod_hold_q[0] = '0;
	end

	// Stage 1 also registers the product of the magnitudes.
	always_ff @(posedge clk) begin
		if (adv) prod_q <= PW'(b_mag_a) * PW'(b_mag_b);
	end

	for (genvar k = 0; k < ST; k++) begin : g_st
		logic [DATA_WIDTH:0]   r_sh;
		logic [DATA_WIDTH+1:0] r_sub;
		logic                  bit_ok;
		always_comb begin
			r_sh   = {rem_q[k][DATA_WIDTH-1:0], num_q[k][NW-1]};
			r_sub  = {1'b0, r_sh} - {2'b0, den_q[k]};
			bit_ok = !r_sub[DATA_WIDTH+1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (adv) begin
				v_q[k+1] <= v_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				act_q[k+1] <= act_q[k];
				neg_q[k+1] <= neg_q[k];
				sim_q[k+1] <= sim_q[k];
				flg_q[k+1] <= flg_q[k];
				den_q[k+1] <= den_q[k];
				prod_hold_q[k+1] <= (k == 1) ? prod_q : prod_hold_q[k];
				if (k < NW) begin
					num_q[k+1] <= {num_q[k][NW-2:0], bit_ok};
					rem_q[k+1] <= bit_ok ? r_sub[DATA_WIDTH:0] : r_sh;
				end else begin
					num_q[k+1] <= num_q[k];
					rem_q[k+1] <= rem_q[k];
				end
			end
		end
	end

	// Final saturation on the registered quotient or shifted product.
	logic [PW-1:0]         mag;
	logic [DATA_WIDTH-1:0] lim, res;
	logic                  ovf;
	fpa_pkg::flags_t       flg;
	always_comb begin
		mag = '0;
		res = sim_q[ST];
		ovf = flg_q[ST].overflow;
		lim = neg_q[ST] ? MINNEG : MAXPOS;
		if (act_q[ST] == fpa_pkg::ACT_MUL) begin
			mag = prod_hold_q[ST] >> FRAC_BITS;
		end else begin
			mag = PW'(num_q[ST]);
		end
		if (act_q[ST] == fpa_pkg::ACT_MUL
			|| (act_q[ST] == fpa_pkg::ACT_DIV && !flg_q[ST].divide_by_zero)) begin
			if (mag[PW-1:DATA_WIDTH] != '0 || mag[DATA_WIDTH-1:0] > lim) begin
				ovf = 1'b1;
				res = lim;
			end else begin
				res = neg_q[ST] ? (~mag[DATA_WIDTH-1:0] + 1'b1) : mag[DATA_WIDTH-1:0];
			end
		end else if (act_q[ST] == fpa_pkg::ACT_DIV) begin
			res = '0;
		end
		flg          = flg_q[ST];
		flg.overflow = ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= last_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_result <= res;
			out_flags  <= flg;
		end
	end

endmodule
`default_nettype wire

### rtl/fixed_point_q24_8_alu.sv
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Signed fixed-point add, subtract, multiply, divide and helpers, saturating.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while out_ready does not stall it, and
// returns one result word per input word, in order. A front end computes the
// comparison flags and every action except multiply and divide and registers
// them, and a two-entry queue passes its words to a back end. The back end is
// a fixed pipeline of DATA_WIDTH+FRAC_BITS+2 stages (42 by default), set by
// the restoring divider that resolves one quotient bit per stage; every action
// takes that path. Multiply and divide are exact and truncate toward zero;
// results beyond the signed range saturate and raise overflow, and a divide by
// zero returns zero with divide_by_zero set.
`default_nettype none
module fixed_point_q24_8_alu #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [3:0]            action,
	input  wire logic [DATA_WIDTH-1:0] operand_a,
	input  wire logic [DATA_WIDTH-1:0] operand_b,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [DATA_WIDTH-1:0]      result,
	output logic                       a_less,
	output logic                       a_equal,
	output logic                       a_greater,
	output logic                       overflow,
	output logic                       divide_by_zero
);
	localparam int QW = 4 + 1 + 3 * DATA_WIDTH + $bits(fpa_pkg::flags_t);

	logic                  f_valid, f_ready, b_valid, b_ready;
	logic [3:0]            f_action, b_action;
	logic                  f_neg, b_neg;
	logic [DATA_WIDTH-1:0] f_mag_a, f_mag_b, f_simple, b_mag_a, b_mag_b, b_simple;
	fpa_pkg::flags_t       f_flags, b_flags, o_flags;

	fpa_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .action, .operand_a, .operand_b,
		.f_valid, .f_ready, .f_action, .f_neg, .f_mag_a, .f_mag_b, .f_simple, .f_flags
	);

	fpa_queue #(.WIDTH(QW)) u_queue (
		.clk, .arst_n,
		.w_valid (f_valid),
		.w_ready (f_ready),
		.w_data  ({f_action, f_neg, f_mag_a, f_mag_b, f_simple, f_flags}),
		.r_valid (b_valid),
		.r_ready (b_ready),
		.r_data  ({b_action, b_neg, b_mag_a, b_mag_b, b_simple, b_flags})
	);

	fpa_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .b_valid, .b_ready, .b_action, .b_neg, .b_mag_a, .b_mag_b,
		.b_simple, .b_flags, .out_valid, .out_ready,
		.out_result (result),
		.out_flags  (o_flags)
	);

	assign a_less         = o_flags.a_less;
	assign a_equal        = o_flags.a_equal;
	assign a_greater      = o_flags.a_greater;
	assign overflow       = o_flags.overflow;
	assign divide_by_zero = o_flags.divide_by_zero;

endmodule
`default_nettype wire

### rtl/fpa_checker.sv
// ----------------------------------------------------------------------------
// Fixed-point ALU port checker
// Checks result flags and the output handshake seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module fpa_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic a_less,
	input wire logic a_equal,
	input wire logic a_greater,
	input wire logic overflow,
	input wire logic divide_by_zero
);
	// Exactly one comparison outcome per result word.
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot({a_less, a_equal, a_greater}))
		else $error("comparison flags not one-hot");

	// A divide by zero never saturates.
	a_dbz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> !overflow)
		else $error("overflow with divide by zero");

	// A stalled result stays valid.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its comparison and overflow flags.
	a_stab: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({a_less, a_equal, a_greater, overflow}))
		else $error("flags changed while stalled");
endmodule

bind fixed_point_q24_8_alu fpa_checker u_fpa_checker (
	.clk, .arst_n, .out_valid, .out_ready, .a_less, .a_equal, .a_greater,
	.overflow, .divide_by_zero
);
`default_nettype wire

### tb/alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU checker
// Watches both channels, predicts each result word and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module alu_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [3:0]  action,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] result,
	input  wire logic        a_less,
	input  wire logic        a_equal,
	input  wire logic        a_greater,
	input  wire logic        overflow,
	input  wire logic        divide_by_zero,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [31:0]     value;
		fpa_pkg::flags_t flags;
	} alu_word_t;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	alu_word_t result_queue[$];

	// Clamp a wide exact value to the signed 32-bit range.
	function automatic logic [32:0] clamp_q(input logic signed [127:0] v);
		if (v > 128'sd2147483647)
			return {1'b1, Q_MAX};
		if (v < -128'sd2147483648)
			return {1'b1, Q_MIN};
		return {1'b0, v[31:0]};
	endfunction

	function automatic alu_word_t compute_alu(input logic [3:0] op, input logic signed [31:0] a,
			input logic signed [31:0] b);
		alu_word_t w;
		logic signed [127:0] wa, wb, prod, quot;
		logic [32:0] sat;
		wa = a;
		wb = b;
		w = '0;
		sat = '0;
		w.flags.a_less = a < b;
		w.flags.a_equal = a == b;
		w.flags.a_greater = a > b;
		case (op)
			fpa_pkg::ACT_ADD: sat = clamp_q(wa + wb);
			fpa_pkg::ACT_SUB: sat = clamp_q(wa - wb);
			fpa_pkg::ACT_MUL: begin
				prod = wa * wb;
				// Truncate toward zero: shift the magnitude.
				if (prod < 0)
					prod = -((-prod) >>> 8);
				else
					prod = prod >>> 8;
				sat = clamp_q(prod);
			end
			fpa_pkg::ACT_DIV: begin
				if (b == 0)
					w.flags.divide_by_zero = 1'b1;
				else begin
					quot = (wa <<< 8) / wb;
					sat = clamp_q(quot);
				end
			end
			fpa_pkg::ACT_MIN: sat = {1'b0, (a < b) ? a : b};
			fpa_pkg::ACT_MAX: sat = {1'b0, (b < a) ? a : b};
			fpa_pkg::ACT_ABS: sat = clamp_q((wa < 0) ? -wa : wa);
			fpa_pkg::ACT_INC: sat = clamp_q(wa + 1);
			fpa_pkg::ACT_DEC: sat = clamp_q(wa - 1);
			fpa_pkg::ACT_TO_INT: sat = {1'b0, a >>> 8};
			fpa_pkg::ACT_FROM_INT: sat = clamp_q(wa <<< 8);
			default: sat = '0;
		endcase
		w.value = sat[31:0];
		w.flags.overflow = sat[32];
		return w;
	endfunction

	assign pending = result_queue.size();

	always @(posedge clk or negedge arst_n) begin
		alu_word_t exp_w;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (in_valid && in_ready)
				result_queue.push_back(compute_alu(action, operand_a, operand_b));
			if (out_valid && out_ready) begin
				if (result_queue.size() == 0) begin
					$error("result word with nothing expected: result %0d", $signed(result));
					fail_count <= fail_count + 1;
				end else begin
					exp_w = result_queue.pop_front();
					if (exp_w.value !== result || exp_w.flags.a_less !== a_less ||
							exp_w.flags.a_equal !== a_equal ||
							exp_w.flags.a_greater !== a_greater ||
							exp_w.flags.overflow !== overflow ||
							exp_w.flags.divide_by_zero !== divide_by_zero)
						fail_count <= fail_count + 1;
					if (exp_w.value !== result)
						$error("result: expected %0d, got %0d", $signed(exp_w.value),
							$signed(result));
					if (exp_w.flags.a_less !== a_less)
						$error("a_less: expected %b, got %b", exp_w.flags.a_less, a_less);
					if (exp_w.flags.a_equal !== a_equal)
						$error("a_equal: expected %b, got %b", exp_w.flags.a_equal, a_equal);
					if (exp_w.flags.a_greater !== a_greater)
						$error("a_greater: expected %b, got %b", exp_w.flags.a_greater,
							a_greater);
					if (exp_w.flags.overflow !== overflow)
						$error("overflow: expected %b, got %b", exp_w.flags.overflow, overflow);
					if (exp_w.flags.divide_by_zero !== divide_by_zero)
						$error("divide_by_zero: expected %b, got %b",
							exp_w.flags.divide_by_zero, divide_by_zero);
				end
			end
		end
	end

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU testbench
// Directed corner words and random traffic with random stalls on both sides;
// a separate checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

	localparam int RANDOM_WORDS = 1200;
	// The pipeline is 42 stages deep, with the front end and queue ahead of it.
	localparam int DRAIN_CYCLES = 60;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  action;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result;
	logic        a_less;
	logic        a_equal;
	logic        a_greater;
	logic        overflow;
	logic        divide_by_zero;
	int          fail_count;
	int          pending;
	int          words_sent;
	int          stall_left;
	bit          sender_calm;
	bit          receiver_calm;

	fixed_point_q24_8_alu u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result         (result),
		.a_less         (a_less),
		.a_equal        (a_equal),
		.a_greater      (a_greater),
		.overflow       (overflow),
		.divide_by_zero (divide_by_zero)
	);

	alu_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.action         (action),
		.operand_a      (operand_a),
		.operand_b      (operand_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result         (result),
		.a_less         (a_less),
		.a_equal        (a_equal),
		.a_greater      (a_greater),
		.overflow       (overflow),
		.divide_by_zero (divide_by_zero),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Operand values skewed toward the places where the arithmetic bends:
	// limits, zero, plus or minus one in Q24.8, small numbers and fully random bits.
	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return ($urandom_range(0, 1) != 0) ? 32'h100 : 32'hffffff00;
			4, 5: return $signed($urandom_range(0, 8191)) - 4096;
			6: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
			default: return $urandom();
		endcase
	endfunction

	// Present one word and hold it until the block takes it. The gap comes
	// first so that valid stays high across back-to-back words.
	task automatic send_word(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// The receiver stalls at random, now and then for a long stretch, with
	// calm stretches where it never does.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else if (receiver_calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 39) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(10, 40);
		end else begin
			out_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	initial begin
		#400000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic [3:0] op;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = '0;
		operand_a = '0;
		operand_b = '0;
		words_sent = 0;
		sender_calm = 1'b0;
		receiver_calm = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: limits on add and subtract, multiply and divide
		// overflow, divide by zero, absolute value of the most negative value,
		// increment and decrement at the limits, conversions and unused codes.
		send_word(fpa_pkg::ACT_ADD, 32'h7fffffff, 32'h1);
		send_word(fpa_pkg::ACT_ADD, 32'h80000000, 32'hffffffff);
		send_word(fpa_pkg::ACT_SUB, 32'h80000000, 32'h1);
		send_word(fpa_pkg::ACT_SUB, 32'h7fffffff, 32'hffffffff);
		send_word(fpa_pkg::ACT_MUL, 32'h7fffffff, 32'h7fffffff);
		send_word(fpa_pkg::ACT_MUL, 32'hfffffe80, 32'h00000180);
		send_word(fpa_pkg::ACT_MUL, 32'h80000000, 32'h100);
		send_word(fpa_pkg::ACT_DIV, 32'h100, 32'h0);
		send_word(fpa_pkg::ACT_DIV, 32'h80000000, 32'hffffffff);
		send_word(fpa_pkg::ACT_DIV, 32'hfffffd00, 32'h00000200);
		send_word(fpa_pkg::ACT_DIV, 32'h00000001, 32'h7fffffff);
		send_word(fpa_pkg::ACT_MIN, 32'h80000000, 32'h7fffffff);
		send_word(fpa_pkg::ACT_MAX, 32'h80000000, 32'h7fffffff);
		send_word(fpa_pkg::ACT_MIN, 32'h5, 32'h5);
		send_word(fpa_pkg::ACT_ABS, 32'h80000000, 32'h0);
		send_word(fpa_pkg::ACT_ABS, 32'hfffffff1, 32'h0);
		send_word(fpa_pkg::ACT_INC, 32'h7fffffff, 32'h0);
		send_word(fpa_pkg::ACT_DEC, 32'h80000000, 32'h0);
		send_word(fpa_pkg::ACT_TO_INT, 32'hffffff7f, 32'h0);
		send_word(fpa_pkg::ACT_TO_INT, 32'h7fffffff, 32'h0);
		send_word(fpa_pkg::ACT_FROM_INT, 32'h00800000, 32'h0);
		send_word(fpa_pkg::ACT_FROM_INT, 32'hff800000, 32'h0);
		send_word(fpa_pkg::ACT_FROM_INT, 32'hff7fffff, 32'h0);
		send_word(4'd11, 32'h1, 32'h2);
		send_word(4'd15, 32'hffffffff, 32'h0);

		// Let everything drain once before random traffic starts.
		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// Alternate calm and busy stretches on both sides.
			if (i % 150 == 0) begin
				sender_calm = ($urandom_range(0, 2) == 0);
				receiver_calm = ($urandom_range(0, 2) == 0);
			end
			op = ($urandom_range(0, 24) == 0) ? 4'($urandom_range(11, 15))
				: 4'($urandom_range(0, 10));
			send_word(op, pick_operand(), ($urandom_range(0, 7) == 0) ? operand_a
				: pick_operand());
			if (i == RANDOM_WORDS / 2) begin
				in_valid <= 1'b0;
				while (pending != 0)
					@(posedge clk);
			end
		end
		in_valid <= 1'b0;
		receiver_calm = 1'b1;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words: all actions and unused codes, corner operands,", words_sent);
		$display("random stalls on both sides and a full drain in mid-run.");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

### files.f
rtl/fpa_pkg.sv
rtl/fpa_front.sv
rtl/fpa_queue.sv
rtl/fpa_back.sv
rtl/fixed_point_q24_8_alu.sv
rtl/fpa_checker.sv
tb/alu_checker.sv
tb/testbench.sv
